@@ design/ahid_pkg.sv @@
`default_nettype none
package ahid_pkg;

   // One report as it leaves the block.
   typedef struct packed {
      logic [1:0]        report_kind;
      logic [7:0]        modifier_mask;
      logic [7:0]        key_code;
      logic [7:0]        button_mask;
      logic signed [7:0] move_x;
      logic signed [7:0] move_y;
      logic signed [7:0] wheel_step;
      logic [15:0]       pos_x;
      logic [15:0]       pos_y;
      logic [7:0]        wait_after_ms;
      logic              last_of_run;
   } ahid_rpt_type;

   // Up to two reports produced by one accepted byte or event.
   typedef struct packed {
      logic [1:0]   count;
      ahid_rpt_type first;
      ahid_rpt_type second;
   } ahid_batch_type;

   // Report kinds.
   localparam logic [1:0] KIND_KEYBOARD = 2'd0;
   localparam logic [1:0] KIND_MOUSE    = 2'd1;
   localparam logic [1:0] KIND_ABS      = 2'd2;

   // Configuration register indexes and reset values.
   localparam logic CSR_PRESS_HOLD = 1'b0;
   localparam logic CSR_KEY_GAP    = 1'b1;
   localparam logic [7:0] PRESS_HOLD_RESET = 8'd5;
   localparam logic [7:0] KEY_GAP_RESET    = 8'd10;

   // Stream bytes with a meaning of their own.
   localparam logic [7:0] BYTE_ESCAPE    = 8'h00;
   localparam logic [7:0] BYTE_BACKSPACE = 8'h08;
   localparam logic [7:0] BYTE_TAB       = 8'h09;
   localparam logic [7:0] BYTE_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_FIRST     = 8'h20;
   localparam logic [7:0] CHAR_LAST      = 8'h7E;

   // Escape codes.
   localparam logic [7:0] SPECIAL_FIRST = 8'h01;
   localparam logic [7:0] SPECIAL_LAST  = 8'h0A;
   localparam logic [7:0] FKEY_FIRST    = 8'h10;
   localparam logic [7:0] FKEY_LAST     = 8'h1B;
   localparam logic [7:0] ESC_ONESHOT   = 8'h81;
   localparam logic [7:0] ESC_HOLD      = 8'h82;
   localparam logic [7:0] ESC_RELEASE   = 8'h83;
   localparam logic [7:0] ESC_MOUSE     = 8'h90;
   localparam logic [7:0] ESC_ABS       = 8'h91;

   // HID usage codes and modifier bits.
   localparam logic [7:0] KEY_NONE      = 8'h00;
   localparam logic [7:0] KEY_ENTER     = 8'h28;
   localparam logic [7:0] KEY_BACKSPACE = 8'h2A;
   localparam logic [7:0] KEY_TAB       = 8'h2B;
   localparam logic [7:0] KEY_F1        = 8'h3A;
   localparam logic [7:0] MOD_NONE      = 8'h00;
   localparam logic [7:0] MOD_LSHIFT    = 8'h02;

   // US layout for 0x20..0x7E; bit 7 marks a character that needs shift.
   localparam logic [7:0] CHAR_MAP [0:94] = '{
      8'h2C, 8'h9E, 8'hB4, 8'hA0, 8'hA1, 8'hA2, 8'hA4, 8'h34,
      8'hA6, 8'hA7, 8'hA5, 8'hAE, 8'h36, 8'h2D, 8'h37, 8'h38,
      8'h27, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
      8'h25, 8'h26, 8'hB3, 8'h33, 8'hB6, 8'h2E, 8'hB7, 8'hB8,
      8'h9F, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8A,
      8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91, 8'h92,
      8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9A,
      8'h9B, 8'h9C, 8'h9D, 8'h2F, 8'h31, 8'h30, 8'hA3, 8'hAD,
      8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A,
      8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10, 8'h11, 8'h12,
      8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A,
      8'h1B, 8'h1C, 8'h1D, 8'hAF, 8'hB1, 8'hB0, 8'hB5
   };

   // Esc, Up, Down, Left, Right, Delete, Home, End, PageUp, PageDown.
   localparam logic [7:0] SPECIAL_MAP [0:9] = '{
      8'h29, 8'h52, 8'h51, 8'h50, 8'h4F, 8'h4C, 8'h4A, 8'h4D, 8'h4B, 8'h4E
   };

   // Builds a keyboard report with all pointer fields cleared.
   function automatic ahid_rpt_type make_kbd(logic [7:0] mods, logic [7:0] key,
                                             logic [7:0] wait_ms);
      ahid_rpt_type r;
      r               = '0;
      r.report_kind   = KIND_KEYBOARD;
      r.modifier_mask = mods;
      r.key_code      = key;
      r.wait_after_ms = wait_ms;
      return r;
   endfunction

endpackage
`default_nettype wire

@@ design/ahid_if.sv @@
`default_nettype none
// Input channel: one stream byte or a disconnect event per transfer.
interface ahid_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] rx_byte;

   modport source (output valid, output action, output rx_byte, input ready);
   modport sink (input valid, input action, input rx_byte, output ready);
endinterface

// Result channel: one HID report per transfer.
interface ahid_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        report_kind;
   logic [7:0]        modifier_mask;
   logic [7:0]        key_code;
   logic [7:0]        button_mask;
   logic signed [7:0] move_x;
   logic signed [7:0] move_y;
   logic signed [7:0] wheel_step;
   logic [15:0]       pos_x;
   logic [15:0]       pos_y;
   logic [7:0]        wait_after_ms;
   logic              last_of_run;

   modport source (output valid, output report_kind, output modifier_mask,
                   output key_code, output button_mask, output move_x,
                   output move_y, output wheel_step, output pos_x, output pos_y,
                   output wait_after_ms, output last_of_run, input ready);
   modport sink (input valid, input report_kind, input modifier_mask,
                 input key_code, input button_mask, input move_x,
                 input move_y, input wheel_step, input pos_x, input pos_y,
                 input wait_after_ms, input last_of_run, output ready);
endinterface
`default_nettype wire

@@ design/ahid_parser.sv @@
`default_nettype none
module ahid_parser (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire logic                    action,
   input  wire logic [7:0]              rx_byte,
   input  wire logic [7:0]              press_hold_ms,
   input  wire logic [7:0]              release_wait_ms,
   output      ahid_pkg::ahid_batch_type batch
);
   import ahid_pkg::*;

   // Parser phases.
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_CODE    = 3'd1;
   localparam logic [2:0] PH_ONESHOT = 3'd2;
   localparam logic [2:0] PH_HOLD    = 3'd3;
   localparam logic [2:0] PH_MOUSE   = 3'd4;
   localparam logic [2:0] PH_ABS     = 3'd5;

   localparam logic [3:0] MOUSE_LEN = 4'd4;
   localparam logic [3:0] ABS_LEN   = 4'd5;
   localparam int         PKT_DEPTH = 5;

   logic [2:0] phase_ff, phase_in;
   logic [2:0] count_ff, count_in;
   logic [7:0] held_ff, held_in;
   logic [7:0] oneshot_ff, oneshot_in;
   logic [7:0] param_bytes_ff [0:PKT_DEPTH-1];

   logic         key_hit;
   logic [7:0]   key_mods;
   logic [7:0]   key_sel;
   logic [7:0]   press_mods;
   logic         one_hit;
   ahid_rpt_type one_rpt;
   logic [7:0]   char_entry;
   logic [6:0]   char_idx;
   logic [3:0]   special_idx;
   logic [3:0]   count_next;

   assign char_idx    = 7'(rx_byte - CHAR_FIRST);
   assign special_idx = 4'(rx_byte - SPECIAL_FIRST);
   assign count_next  = {1'b0, count_ff} + 4'd1;
   assign press_mods  = key_mods | held_ff | oneshot_ff;

   // Next state and the reports of the current byte or event.
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      held_in    = held_ff;
      oneshot_in = oneshot_ff;
      key_hit    = 1'b0;
      key_mods   = MOD_NONE;
      key_sel    = KEY_NONE;
      one_hit    = 1'b0;
      one_rpt    = '0;
      char_entry = CHAR_MAP[char_idx];

      if (action) begin
         phase_in = PH_IDLE;
         count_in = '0;
         if ((held_ff != 8'd0) || (oneshot_ff != 8'd0)) begin
            held_in    = '0;
            oneshot_in = '0;
            one_hit    = 1'b1;
            one_rpt    = make_kbd(MOD_NONE, KEY_NONE, 8'd0);
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               case (rx_byte) inside
                  BYTE_ESCAPE: phase_in = PH_CODE;
                  BYTE_NEWLINE: begin
                     key_hit = 1'b1;
                     key_sel = KEY_ENTER;
                  end
                  BYTE_TAB: begin
                     key_hit = 1'b1;
                     key_sel = KEY_TAB;
                  end
                  BYTE_BACKSPACE: begin
                     key_hit = 1'b1;
                     key_sel = KEY_BACKSPACE;
                  end
                  [CHAR_FIRST:CHAR_LAST]: begin
                     key_hit  = 1'b1;
                     key_mods = char_entry[7] ? MOD_LSHIFT : MOD_NONE;
                     key_sel  = {1'b0, char_entry[6:0]};
                  end
                  default: ;
               endcase
            end
            PH_CODE: begin
               phase_in = PH_IDLE;
               case (rx_byte) inside
                  ESC_ONESHOT: phase_in = PH_ONESHOT;
                  ESC_HOLD: phase_in = PH_HOLD;
                  ESC_RELEASE: begin
                     held_in    = '0;
                     oneshot_in = '0;
                     one_hit    = 1'b1;
                     one_rpt    = make_kbd(MOD_NONE, KEY_NONE, 8'd0);
                  end
                  ESC_MOUSE: begin
                     count_in = '0;
                     phase_in = PH_MOUSE;
                  end
                  ESC_ABS: begin
                     count_in = '0;
                     phase_in = PH_ABS;
                  end
                  [SPECIAL_FIRST:SPECIAL_LAST]: begin
                     key_hit = 1'b1;
                     key_sel = SPECIAL_MAP[special_idx];
                  end
                  [FKEY_FIRST:FKEY_LAST]: begin
                     key_hit = 1'b1;
                     key_sel = rx_byte - FKEY_FIRST + KEY_F1;
                  end
                  default: ;
               endcase
            end
            PH_ONESHOT: begin
               oneshot_in = rx_byte;
               phase_in   = PH_IDLE;
            end
            PH_HOLD: begin
               held_in    = rx_byte;
               oneshot_in = '0;
               phase_in   = PH_IDLE;
               one_hit    = 1'b1;
               one_rpt    = make_kbd(rx_byte, KEY_NONE, 8'd0);
            end
            PH_MOUSE: begin
               if (count_next >= MOUSE_LEN) begin
                  count_in            = '0;
                  phase_in            = PH_IDLE;
                  one_hit             = 1'b1;
                  one_rpt.report_kind = KIND_MOUSE;
                  one_rpt.button_mask = param_bytes_ff[0];
                  one_rpt.move_x      = $signed(param_bytes_ff[1]);
                  one_rpt.move_y      = $signed(param_bytes_ff[2]);
                  one_rpt.wheel_step  = $signed(rx_byte);
               end else begin
                  count_in = count_next[2:0];
               end
            end
            PH_ABS: begin
               if (count_next >= ABS_LEN) begin
                  count_in            = '0;
                  phase_in            = PH_IDLE;
                  one_hit             = 1'b1;
                  one_rpt.report_kind = KIND_ABS;
                  one_rpt.button_mask = param_bytes_ff[0];
                  one_rpt.pos_x       = {param_bytes_ff[2], param_bytes_ff[1]};
                  one_rpt.pos_y       = {rx_byte, param_bytes_ff[3]};
               end else begin
                  count_in = count_next[2:0];
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end

      // A keystroke is a press and a release; the release keeps held modifiers.
      batch = '0;
      if (key_hit) begin
         oneshot_in               = '0;
         batch.count              = 2'd2;
         batch.first              = make_kbd(press_mods, key_sel, press_hold_ms);
         batch.second             = make_kbd(held_ff, KEY_NONE, release_wait_ms);
         batch.second.last_of_run = 1'b1;
      end else if (one_hit) begin
         batch.count             = 2'd1;
         batch.first             = one_rpt;
         batch.first.last_of_run = 1'b1;
      end
   end

   // Parser state advances on each accepted transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         count_ff   <= '0;
         held_ff    <= '0;
         oneshot_ff <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         held_ff    <= held_in;
         oneshot_ff <= oneshot_in;
      end
   end

   // Packet bytes are stored at the current gather position.
   always_ff @(posedge clock) begin
      if (accept && !action && ((phase_ff == PH_MOUSE) || (phase_ff == PH_ABS))) begin
         for (int i = 0; i < PKT_DEPTH; i++) begin
            if (count_ff == 3'(i)) begin
               param_bytes_ff[i] <= rx_byte;
            end
         end
      end
   end

`ifndef SYNTH
   // The gather position never reaches the packet length.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_MOUSE) |-> (count_ff < MOUSE_LEN[2:0]))
      else $error("mouse gather position out of range");

   a_abs_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < ABS_LEN[2:0])
      else $error("pointer gather position out of range");

   // A disconnect leaves the parser idle with no modifiers.
   a_disconnect: assert property (@(posedge clock) disable iff (reset)
      (accept && action) |=>
         ((phase_ff == PH_IDLE) && (count_ff == 3'd0) && (held_ff == 8'd0) &&
          (oneshot_ff == 8'd0)))
      else $error("disconnect did not clear parser state");
`endif

endmodule
`default_nettype wire

@@ design/ascii_escape_to_hid_reports.sv @@
// Converts a byte stream of ASCII text and escape commands into USB HID
// keyboard, relative-mouse and absolute-pointer reports (US layout). Each
// transfer on req_chan is a stream byte or, with action set, a disconnect.
// A byte is parsed in the cycle it is accepted and its reports (none, one,
// or two for a keystroke) land in a two-entry report buffer that drains one
// report per cycle into the rsp_chan output register while the output side
// takes them. A new transfer is taken when that buffer is empty or when its
// last report moves to the output register in the same cycle. A stalled
// output side stalls the input once the buffer holds reports. The last report
// caused by an item carries last_of_run. The press hold and key gap times are
// written through csr_we/csr_index/csr_wdata; the user must do so only while
// idle, as the block itself does not enforce it.
`default_nettype none
module ascii_escape_to_hid_reports (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata,
   ahid_req_if.sink        req_chan,
   ahid_rsp_if.source      rsp_chan
);
   import ahid_pkg::*;

   logic [7:0]     press_hold_ff;
   logic [7:0]     key_gap_ff;
   ahid_batch_type batch;
   ahid_rpt_type   buf0_ff, buf1_ff;
   logic [1:0]     fill_ff;
   ahid_rpt_type   out_ff;
   logic           out_valid_ff;
   logic           accept;
   logic           move;

   // The input is open when the buffer is empty or its last report leaves now.
   assign req_chan.ready = (fill_ff == 2'd0) || ((fill_ff == 2'd1) && move);
   assign accept         = req_chan.valid && req_chan.ready;
   assign move           = (fill_ff != 2'd0) && (!out_valid_ff || rsp_chan.ready);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         press_hold_ff <= PRESS_HOLD_RESET;
         key_gap_ff    <= KEY_GAP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PRESS_HOLD: press_hold_ff <= csr_wdata;
            CSR_KEY_GAP:    key_gap_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   ahid_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .action          (req_chan.action),
      .rx_byte         (req_chan.rx_byte),
      .press_hold_ms   (press_hold_ff),
      .release_wait_ms (key_gap_ff),
      .batch           (batch)
   );

   // Report buffer fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= batch.count;
      end else if (move) begin
         fill_ff <= fill_ff - 2'd1;
      end
   end

   // Report buffer entries; the head shifts out one report per move.
   always_ff @(posedge clock) begin
      if (accept) begin
         buf0_ff <= batch.first;
         buf1_ff <= batch.second;
      end else if (move) begin
         buf0_ff <= buf1_ff;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         out_ff <= buf0_ff;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.report_kind   = out_ff.report_kind;
   assign rsp_chan.modifier_mask = out_ff.modifier_mask;
   assign rsp_chan.key_code      = out_ff.key_code;
   assign rsp_chan.button_mask   = out_ff.button_mask;
   assign rsp_chan.move_x        = out_ff.move_x;
   assign rsp_chan.move_y        = out_ff.move_y;
   assign rsp_chan.wheel_step    = out_ff.wheel_step;
   assign rsp_chan.pos_x         = out_ff.pos_x;
   assign rsp_chan.pos_y         = out_ff.pos_y;
   assign rsp_chan.wait_after_ms = out_ff.wait_after_ms;
   assign rsp_chan.last_of_run   = out_ff.last_of_run;

`ifndef SYNTH
   // The buffer never holds more than one keystroke.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3)
      else $error("report buffer overfilled");

   // A lone buffered report always closes its run.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd1) |-> buf0_ff.last_of_run)
      else $error("last buffered report lacks last_of_run");

   // With two reports buffered only the second closes the run.
   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd2) |-> (!buf0_ff.last_of_run && buf1_ff.last_of_run))
      else $error("report pair marked wrongly");

   // An accepted transfer fills the buffer with exactly its reports.
   a_fill_load: assert property (@(posedge clock) disable iff (reset)
      accept |=> (fill_ff == $past(batch.count)))
      else $error("report buffer fill mismatch");
`endif

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ahid_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 16;

   // Parser phases of the byte stream.
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CODE,
      PH_ONESHOT,
      PH_HOLD,
      PH_MOUSE,
      PH_ABS
   } parse_phase_type;

   // US layout for 0x20..0x7E; bit 7 set means the character needs left shift.
   localparam logic [7:0] US_KEY_OF_CHAR [0:94] = '{
      8'h2C, 8'h9E, 8'hB4, 8'hA0, 8'hA1, 8'hA2, 8'hA4, 8'h34,
      8'hA6, 8'hA7, 8'hA5, 8'hAE, 8'h36, 8'h2D, 8'h37, 8'h38,
      8'h27, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
      8'h25, 8'h26, 8'hB3, 8'h33, 8'hB6, 8'h2E, 8'hB7, 8'hB8,
      8'h9F, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8A,
      8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91, 8'h92,
      8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9A,
      8'h9B, 8'h9C, 8'h9D, 8'h2F, 8'h31, 8'h30, 8'hA3, 8'hAD,
      8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A,
      8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10, 8'h11, 8'h12,
      8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A,
      8'h1B, 8'h1C, 8'h1D, 8'hAF, 8'hB1, 8'hB0, 8'hB5
   };

   // Escape codes 0x01..0x0A: Esc, arrows, Delete, Home, End, PageUp, PageDown.
   localparam logic [7:0] NAV_KEY_OF_CODE [0:9] = '{
      8'h29, 8'h52, 8'h51, 8'h50, 8'h4F, 8'h4C, 8'h4A, 8'h4D, 8'h4B, 8'h4E
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we;
   logic       csr_index;
   logic [7:0] csr_wdata;

   ahid_req_if req_chan ();
   ahid_rsp_if rsp_chan ();

   ascii_escape_to_hid_reports u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   always #2 clock = ~clock;

   // Shadow of the block's parser state and timing registers.
   parse_phase_type phase_q = PH_IDLE;
   logic [2:0]      packet_len = '0;
   logic [7:0]      packet_data [0:4];
   logic [7:0]      hold_mask = MOD_NONE;
   logic [7:0]      armed_mods = MOD_NONE;
   logic [7:0]      hold_ms = PRESS_HOLD_RESET;
   logic [7:0]      gap_ms = KEY_GAP_RESET;

   ahid_rpt_type expected_reports [$];

   int source_idle_pct = 0;
   int sink_idle_pct   = 0;
   int hold_off_left   = 0;
   int cycle_count     = 0;
   int mismatch_count  = 0;
   int items_sent      = 0;
   int reports_checked = 0;

   function automatic ahid_rpt_type key_report(logic [7:0] mods, logic [7:0] key,
                                               logic [7:0] wait_ms);
      ahid_rpt_type r;
      r               = '0;
      r.report_kind   = KIND_KEYBOARD;
      r.modifier_mask = mods;
      r.key_code      = key;
      r.wait_after_ms = wait_ms;
      return r;
   endfunction

   // A keystroke is a press with every active modifier, then a release that
   // keeps only the held ones. One-shot modifiers are used up by the press.
   function automatic void push_keystroke(logic [7:0] char_mods, logic [7:0] key);
      logic [7:0] press;
      press      = char_mods | hold_mask | armed_mods;
      armed_mods = MOD_NONE;
      expected_reports.push_back(key_report(press, key, hold_ms));
      expected_reports.push_back(key_report(hold_mask, KEY_NONE, gap_ms));
   endfunction

   // Works out the reports that one accepted transfer causes.
   function automatic void predict_reports(logic is_disconnect, logic [7:0] rx);
      int           count_before;
      logic [7:0]   entry;
      ahid_rpt_type r;
      count_before = expected_reports.size();
      if (is_disconnect) begin
         phase_q    = PH_IDLE;
         packet_len = '0;
         if (hold_mask != MOD_NONE || armed_mods != MOD_NONE) begin
            hold_mask  = MOD_NONE;
            armed_mods = MOD_NONE;
            expected_reports.push_back(key_report(MOD_NONE, KEY_NONE, 8'd0));
         end
      end else begin
         case (phase_q)
            PH_IDLE: begin
               if (rx == BYTE_ESCAPE) begin
                  phase_q = PH_CODE;
               end else if (rx == BYTE_NEWLINE) begin
                  push_keystroke(MOD_NONE, KEY_ENTER);
               end else if (rx == BYTE_TAB) begin
                  push_keystroke(MOD_NONE, KEY_TAB);
               end else if (rx == BYTE_BACKSPACE) begin
                  push_keystroke(MOD_NONE, KEY_BACKSPACE);
               end else if (rx >= CHAR_FIRST && rx <= CHAR_LAST) begin
                  entry = US_KEY_OF_CHAR[7'(rx - CHAR_FIRST)];
                  push_keystroke(entry[7] ? MOD_LSHIFT : MOD_NONE, {1'b0, entry[6:0]});
               end
            end
            PH_CODE: begin
               phase_q = PH_IDLE;
               if (rx == ESC_ONESHOT) begin
                  phase_q = PH_ONESHOT;
               end else if (rx == ESC_HOLD) begin
                  phase_q = PH_HOLD;
               end else if (rx == ESC_RELEASE) begin
                  hold_mask  = MOD_NONE;
                  armed_mods = MOD_NONE;
                  expected_reports.push_back(key_report(MOD_NONE, KEY_NONE, 8'd0));
               end else if (rx == ESC_MOUSE) begin
                  packet_len = '0;
                  phase_q    = PH_MOUSE;
               end else if (rx == ESC_ABS) begin
                  packet_len = '0;
                  phase_q    = PH_ABS;
               end else if (rx >= SPECIAL_FIRST && rx <= SPECIAL_LAST) begin
                  push_keystroke(MOD_NONE, NAV_KEY_OF_CODE[4'(rx - SPECIAL_FIRST)]);
               end else if (rx >= FKEY_FIRST && rx <= FKEY_LAST) begin
                  push_keystroke(MOD_NONE, KEY_F1 + (rx - FKEY_FIRST));
               end
            end
            PH_ONESHOT: begin
               armed_mods = rx;
               phase_q    = PH_IDLE;
            end
            PH_HOLD: begin
               hold_mask  = rx;
               armed_mods = MOD_NONE;
               phase_q    = PH_IDLE;
               expected_reports.push_back(key_report(hold_mask, KEY_NONE, 8'd0));
            end
            PH_MOUSE, PH_ABS: begin
               packet_data[packet_len] = rx;
               packet_len = packet_len + 3'd1;
               if (phase_q == PH_MOUSE && packet_len == 3'd4) begin
                  r             = '0;
                  r.report_kind = KIND_MOUSE;
                  r.button_mask = packet_data[0];
                  r.move_x      = packet_data[1];
                  r.move_y      = packet_data[2];
                  r.wheel_step  = packet_data[3];
                  expected_reports.push_back(r);
                  packet_len = '0;
                  phase_q    = PH_IDLE;
               end else if (phase_q == PH_ABS && packet_len == 3'd5) begin
                  r             = '0;
                  r.report_kind = KIND_ABS;
                  r.button_mask = packet_data[0];
                  r.pos_x       = {packet_data[2], packet_data[1]};
                  r.pos_y       = {packet_data[4], packet_data[3]};
                  expected_reports.push_back(r);
                  packet_len = '0;
                  phase_q    = PH_IDLE;
               end
            end
            default: phase_q = PH_IDLE;
         endcase
      end
      // The last report of the transfer closes the run.
      if (expected_reports.size() > count_before) begin
         r             = expected_reports.pop_back();
         r.last_of_run = 1'b1;
         expected_reports.push_back(r);
      end
   endfunction

   function automatic string report_text(ahid_rpt_type r);
      return $sformatf({"kind=%0d mods=%02h key=%02h btn=%02h dx=%0d dy=%0d wh=%0d ",
                        "x=%04h y=%04h wait=%0d last=%0b"},
                       r.report_kind, r.modifier_mask, r.key_code, r.button_mask,
                       r.move_x, r.move_y, r.wheel_step, r.pos_x, r.pos_y,
                       r.wait_after_ms, r.last_of_run);
   endfunction

   // Offers one item after a random gap and waits for its transfer.
   // Called and returns at a falling edge.
   task automatic send_item(input logic is_disconnect, input logic [7:0] rx);
      while ($urandom_range(99) < source_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.action  <= is_disconnect;
      req_chan.rx_byte <= rx;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_reports(is_disconnect, rx);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_bytes(input logic [7:0] seq [$]);
      foreach (seq[i]) send_item(1'b0, seq[i]);
   endtask

   // Stops offering, waits for every expected report, then lets the block settle.
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Writes both timing registers on back-to-back cycles while the block is idle.
   task automatic set_timing(input logic [7:0] hold, input logic [7:0] gap);
      csr_we    <= 1'b1;
      csr_index <= CSR_PRESS_HOLD;
      csr_wdata <= hold;
      @(negedge clock);
      hold_ms    = hold;
      csr_index <= CSR_KEY_GAP;
      csr_wdata <= gap;
      @(negedge clock);
      gap_ms  = gap;
      csr_we <= 1'b0;
   endtask

   function automatic logic [7:0] random_char();
      return 8'($urandom_range(CHAR_LAST, CHAR_FIRST));
   endfunction

   function automatic logic [7:0] random_byte();
      return 8'($urandom_range(255));
   endfunction

   // One random command: mostly well-formed sequences, some noise and
   // sequences cut short. Returns how many items count toward the goal.
   task automatic send_random_sequence(output int counted);
      int         pick;
      int         i;
      int         cut;
      logic [7:0] rx;
      pick    = $urandom_range(99);
      counted = 0;
      if (pick < 40) begin
         case ($urandom_range(9))
            0:       rx = BYTE_NEWLINE;
            1:       rx = BYTE_TAB;
            2:       rx = BYTE_BACKSPACE;
            default: rx = random_char();
         endcase
         send_item(1'b0, rx);
         counted = 1;
      end else if (pick < 50) begin
         send_item(1'b0, BYTE_ESCAPE);
         if ($urandom_range(1) == 0) begin
            send_item(1'b0, 8'($urandom_range(SPECIAL_LAST, SPECIAL_FIRST)));
         end else begin
            send_item(1'b0, 8'($urandom_range(FKEY_LAST, FKEY_FIRST)));
         end
         counted = 2;
      end else if (pick < 58) begin
         send_bytes('{BYTE_ESCAPE, ESC_ONESHOT, random_byte(), random_char()});
         counted = 4;
      end else if (pick < 66) begin
         send_bytes('{BYTE_ESCAPE, ESC_HOLD, random_byte()});
         counted = 3;
      end else if (pick < 70) begin
         send_bytes('{BYTE_ESCAPE, ESC_RELEASE});
         counted = 2;
      end else if (pick < 78) begin
         send_bytes('{BYTE_ESCAPE, ESC_MOUSE, random_byte(), random_byte(),
                      random_byte(), random_byte()});
         counted = 6;
      end else if (pick < 86) begin
         send_bytes('{BYTE_ESCAPE, ESC_ABS, random_byte(), random_byte(),
                      random_byte(), random_byte(), random_byte()});
         counted = 7;
      end else if (pick < 90) begin
         send_item(1'b1, random_byte());
         counted = 1;
      end else if (pick < 95) begin
         // Noise: any byte at all, which may also open an escape.
         send_item(1'b0, random_byte());
      end else begin
         // Broken sequences: any code after an escape, or a command cut by a disconnect.
         send_item(1'b0, BYTE_ESCAPE);
         case ($urandom_range(2))
            0: send_item(1'b0, random_byte());
            1: begin
               send_item(1'b0, ($urandom_range(1) == 0) ? ESC_MOUSE : ESC_ABS);
               cut = $urandom_range(3);
               for (i = 0; i < cut; i++) send_item(1'b0, random_byte());
               send_item(1'b1, random_byte());
            end
            default: begin
               send_item(1'b0, ($urandom_range(1) == 0) ? ESC_ONESHOT : ESC_HOLD);
               send_item(1'b1, random_byte());
            end
         endcase
         counted = 2;
      end
   endtask

   // Printable extremes, the three control keys and a dropped byte.
   task automatic test_text_keys();
      send_bytes('{CHAR_FIRST, CHAR_LAST, BYTE_NEWLINE, BYTE_TAB, BYTE_BACKSPACE, 8'hFF});
   endtask

   // First navigation key, last function key and an unknown escape code.
   task automatic test_escape_keys();
      send_bytes('{BYTE_ESCAPE, SPECIAL_FIRST, BYTE_ESCAPE, FKEY_LAST, BYTE_ESCAPE, 8'h7F});
   endtask

   // One-shot arm and use, hold, disconnect with modifiers held, release all.
   task automatic test_modifiers();
      send_bytes('{BYTE_ESCAPE, ESC_ONESHOT, 8'hFF, 8'h41, BYTE_ESCAPE, ESC_HOLD, 8'h80});
      send_item(1'b1, 8'h00);
      send_bytes('{BYTE_ESCAPE, ESC_RELEASE});
   endtask

   // Relative mouse packet with the signed extremes.
   task automatic test_pointer_packets();
      send_bytes('{BYTE_ESCAPE, ESC_MOUSE, 8'hFF, 8'h80, 8'h7F, 8'h00});
   endtask

   task automatic test_random_traffic(input int src_pct, input int dst_pct, input int goal);
      int counted;
      int done;
      source_idle_pct = src_pct;
      sink_idle_pct   = dst_pct;
      done            = 0;
      while (done < goal) begin
         send_random_sequence(counted);
         done += counted;
      end
      wait_for_drain();
   endtask

   // The output side stalls for a long stretch while keystrokes keep coming,
   // so the report buffer fills and the input must stall.
   task automatic test_output_stall();
      int i;
      source_idle_pct = 0;
      sink_idle_pct   = 0;
      hold_off_left   = 400;
      for (i = 0; i < 40; i++) send_item(1'b0, random_char());
      wait_for_drain();
   endtask

   // Result side ready, with random idling and an occasional long hold-off.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_off_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   // Compares each report transfer with the oldest expected report.
   always @(posedge clock) begin
      ahid_rpt_type got;
      ahid_rpt_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.report_kind   = rsp_chan.report_kind;
         got.modifier_mask = rsp_chan.modifier_mask;
         got.key_code      = rsp_chan.key_code;
         got.button_mask   = rsp_chan.button_mask;
         got.move_x        = rsp_chan.move_x;
         got.move_y        = rsp_chan.move_y;
         got.wheel_step    = rsp_chan.wheel_step;
         got.pos_x         = rsp_chan.pos_x;
         got.pos_y         = rsp_chan.pos_y;
         got.wait_after_ms = rsp_chan.wait_after_ms;
         got.last_of_run   = rsp_chan.last_of_run;
         if (expected_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected report at cycle %0d: %s", cycle_count, report_text(got));
         end else begin
            want = expected_reports.pop_front();
            reports_checked++;
            if (got.report_kind !== want.report_kind ||
                got.modifier_mask !== want.modifier_mask ||
                got.key_code !== want.key_code ||
                got.button_mask !== want.button_mask ||
                got.move_x !== want.move_x ||
                got.move_y !== want.move_y ||
                got.wheel_step !== want.wheel_step ||
                got.pos_x !== want.pos_x ||
                got.pos_y !== want.pos_y ||
                got.wait_after_ms !== want.wait_after_ms ||
                got.last_of_run !== want.last_of_run) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Wrong report %0d at cycle %0d", reports_checked, cycle_count);
                  $display("   expected %s", report_text(want));
                  $display("   actual   %s", report_text(got));
               end
            end
         end
      end
   end

   // Guards against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d reports outstanding.",
                  cycle_count, expected_reports.size());
         $display("ascii_escape_to_hid_reports: mismatch");
         $finish;
      end
   end

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.action  = 1'b0;
      req_chan.rx_byte = 8'h00;
      csr_we           = 1'b0;
      csr_index        = CSR_PRESS_HOLD;
      csr_wdata        = 8'h00;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed checks run with the timing registers at their reset values.
      source_idle_pct = 15;
      sink_idle_pct   = 68;
      test_text_keys();
      test_escape_keys();
      test_modifiers();
      test_pointer_packets();
      wait_for_drain();

      set_timing(8'd0, 8'hFF);
      test_random_traffic(15, 68, 320);
      set_timing(8'hFF, 8'd0);
      test_random_traffic(68, 15, 320);
      set_timing(random_byte(), random_byte());
      test_random_traffic(0, 0, 320);
      test_output_stall();

      $display("Covered %0d input transfers and %0d reports: text, escapes, modifiers,",
               items_sent, reports_checked);
      $display("pointer packets and disconnects under three idle patterns and a long stall.");
      if (mismatch_count == 0) begin
         $display("ascii_escape_to_hid_reports: match");
      end else begin
         $display("%0d mismatching reports.", mismatch_count);
         $display("ascii_escape_to_hid_reports: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire
